// ===== rtl/lsfe_pkg.sv =====
// Shared types, widths and constants for the Lagrange shape function evaluator.
package lsfe_pkg;

    // Fixed-point format of coordinates and results.
    localparam int FRAC_BITS = 16;
    localparam int XW        = 18;
    localparam int OUT_W     = 20;
    localparam int NODE_W    = 4;

    // Internal operand widths: linear terms, factor terms, stage operands and products.
    localparam int LIN_W   = 22;
    localparam int FAC_W   = 19;
    localparam int OP_W    = 38;
    localparam int HALF_W  = OP_W / 2;
    localparam int PP_W    = 2 * (HALF_W + 1);
    localparam int PROD_W  = 2 * OP_W;
    localparam int SHIFT_W = $clog2(3 * FRAC_BITS + 3);

    // Result lanes: basis value, derivative in xi, derivative in eta.
    localparam int NLANE   = 3;
    localparam int LANE_V  = 0;
    localparam int LANE_DX = 1;
    localparam int LANE_DY = 2;

    // Saturation limits of a result, held at product width.
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

    // Element kind codes.
    typedef enum logic [2:0] {
        KIND_LINE1 = 3'd0,
        KIND_LINE2 = 3'd1,
        KIND_QUAD1 = 3'd2,
        KIND_QUAD2 = 3'd3,
        KIND_TRI1  = 3'd4,
        KIND_TRI2  = 3'd5
    } t_kind;

    // Operands of one result lane: (a1 * a2) * (b1 * b2), rounded right by sh bits.
    typedef struct packed {
        logic [LIN_W-1:0]   a1;
        logic [FAC_W-1:0]   a2;
        logic [LIN_W-1:0]   b1;
        logic [FAC_W-1:0]   b2;
        logic [SHIFT_W-1:0] sh;
    } t_lane_op;

    // Node identity that travels with each result through the pipeline.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } t_tag;

    // Number of basis nodes of an element kind; unused codes have none.
    function automatic logic [NODE_W-1:0] node_count(input logic [2:0] kind);
        logic [NODE_W-1:0] n;
        unique case (kind)
            KIND_LINE1: n = NODE_W'(2);
            KIND_LINE2: n = NODE_W'(3);
            KIND_QUAD1: n = NODE_W'(4);
            KIND_QUAD2: n = NODE_W'(9);
            KIND_TRI1:  n = NODE_W'(3);
            KIND_TRI2:  n = NODE_W'(6);
            default:    n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/lagrange_shape_function_eval.sv =====
// Lagrange shape function evaluator for line, quadrilateral and triangle elements.
//
// Each transfer on the input channel names an element kind and a reference point (xi, eta)
// and produces one result per basis node, in node order, with the last node marked: 2 for
// the linear line, 3 for the quadratic line, 4 and 9 for the quadrilaterals, 3 and 6 for the
// triangles, none for the two unused kind codes. A node sequencer issues one node per cycle,
// while the output is not stalled, into a five-stage arithmetic pipeline (operand build,
// factor multiply, four partial products, sum and rounding, shift and saturate), so an item
// occupies the sequencer until its last node is issued (an unused code does not occupy it)
// and the next item is taken while the last node of the current one is issued. Results are
// rounded to nearest at 16 fraction bits and saturate to 20 bits, and any stall on the
// output holds the whole pipeline.
module lagrange_shape_function_eval (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [2:0]                           i_func,
    input  logic signed [lsfe_pkg::XW-1:0]       i_xi,
    input  logic signed [lsfe_pkg::XW-1:0]       i_eta,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lsfe_pkg::NODE_W-1:0]          o_node_index,
    output logic signed [lsfe_pkg::OUT_W-1:0]    o_basis_value,
    output logic signed [lsfe_pkg::OUT_W-1:0]    o_deriv_xi,
    output logic signed [lsfe_pkg::OUT_W-1:0]    o_deriv_eta,
    output logic                                 o_last_node
);
    import lsfe_pkg::*;

    localparam logic signed [LIN_W-1:0] ONE_L  = LIN_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [LIN_W-1:0] UNIT_L = LIN_W'(1);
    localparam logic signed [FAC_W-1:0] FAC_ONE = FAC_W'(1);
    localparam logic [SHIFT_W-1:0] SH_0  = SHIFT_W'(0);
    localparam logic [SHIFT_W-1:0] SH_1  = SHIFT_W'(1);
    localparam logic [SHIFT_W-1:0] SH_2  = SHIFT_W'(2);
    localparam logic [SHIFT_W-1:0] SH_F  = SHIFT_W'(FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_F1 = SHIFT_W'(FRAC_BITS + 1);
    localparam logic [SHIFT_W-1:0] SH_F2 = SHIFT_W'(FRAC_BITS + 2);
    localparam logic [SHIFT_W-1:0] SH_2F = SHIFT_W'(2 * FRAC_BITS);
    localparam logic [SHIFT_W-1:0] SH_3F = SHIFT_W'(3 * FRAC_BITS);

    // Pack the operands of one lane.
    function automatic t_lane_op mk(input logic [LIN_W-1:0] a1, input logic [FAC_W-1:0] a2,
                                    input logic [LIN_W-1:0] b1, input logic [FAC_W-1:0] b2,
                                    input logic [SHIFT_W-1:0] sh);
        t_lane_op op;
        op.a1 = a1;
        op.a2 = a2;
        op.b1 = b1;
        op.b2 = b2;
        op.sh = sh;
        return op;
    endfunction

    // A lane that is a single linear term.
    function automatic t_lane_op lin(input logic [LIN_W-1:0] v, input logic [SHIFT_W-1:0] sh);
        return mk(v, FAC_ONE, UNIT_L, FAC_ONE, sh);
    endfunction

    // One-dimensional quadratic factors: the value is qp * qq, the slope is qd.
    function automatic logic signed [LIN_W-1:0] qp(input logic signed [LIN_W-1:0] v,
                                                   input logic [1:0] idx);
        logic signed [LIN_W-1:0] r;
        case (idx)
            2'd1:    r = ONE_L - v;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic signed [LIN_W-1:0] qq(input logic signed [LIN_W-1:0] v,
                                                   input logic [1:0] idx);
        logic signed [LIN_W-1:0] r;
        case (idx)
            2'd0:    r = v - ONE_L;
            default: r = v + ONE_L;
        endcase
        return r;
    endfunction

    function automatic logic signed [LIN_W-1:0] qd(input logic signed [LIN_W-1:0] v,
                                                   input logic [1:0] idx);
        logic signed [LIN_W-1:0] r;
        case (idx)
            2'd0:    r = (v <<< 1) - ONE_L;
            2'd1:    r = -(v <<< 1);
            default: r = (v <<< 1) + ONE_L;
        endcase
        return r;
    endfunction

    // Sequencer state.
    logic                    r_busy;
    logic [2:0]              r_kind;
    logic signed [XW-1:0]    r_x;
    logic signed [XW-1:0]    r_y;
    logic [NODE_W-1:0]       r_k;
    logic [NODE_W-1:0]       r_cnt;

    // Pipeline valid bits and payload.
    logic                    r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    t_tag                    r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    t_lane_op                r_op1 [NLANE];
    logic signed [OP_W-1:0]  r_opa2 [NLANE];
    logic signed [OP_W-1:0]  r_opb2 [NLANE];
    logic [SHIFT_W-1:0]      r_sh2 [NLANE];
    logic signed [PP_W-1:0]  r_hh3 [NLANE];
    logic signed [PP_W-1:0]  r_hl3 [NLANE];
    logic signed [PP_W-1:0]  r_lh3 [NLANE];
    logic signed [PP_W-1:0]  r_ll3 [NLANE];
    logic [SHIFT_W-1:0]      r_sh3 [NLANE];
    logic signed [PROD_W-1:0] r_sum4 [NLANE];
    logic [SHIFT_W-1:0]      r_sh4 [NLANE];
    logic signed [OUT_W-1:0] r_res5 [NLANE];

    logic                    advance;
    logic                    seq_last;
    logic                    emit;
    logic                    accept;
    logic [NODE_W-1:0]       in_cnt;

    // Operand build signals.
    logic signed [LIN_W-1:0] xs, ys, lx_m1, lx_p1, l1_mx, ly_m1, ly_p1, l1_my, ll;
    logic signed [LIN_W-1:0] x2, x4, x8, y2, y4, y8, one3, one4;
    logic [1:0]              qa, qb, ia;
    logic                    ea, eb;
    logic [SHIFT_W-1:0]      sh_v, sh_d;
    t_lane_op                ops [NLANE];

    // Arithmetic stage signals.
    logic signed [LIN_W+FAC_W-1:0] mul_a [NLANE];
    logic signed [LIN_W+FAC_W-1:0] mul_b [NLANE];
    logic signed [HALF_W:0]        ahe [NLANE];
    logic signed [HALF_W:0]        ale [NLANE];
    logic signed [HALF_W:0]        bhe [NLANE];
    logic signed [HALF_W:0]        ble [NLANE];
    logic signed [PROD_W-1:0]      rnd [NLANE];
    logic signed [PROD_W-1:0]      sum [NLANE];
    logic signed [PROD_W-1:0]      shifted [NLANE];
    logic signed [OUT_W-1:0]       sat [NLANE];

    // Handshake: the whole pipeline moves when the output register is free or being taken.
    assign advance     = !r_vld5 || i_out_ready;
    assign seq_last    = (r_k == r_cnt - NODE_W'(1));
    assign emit        = r_busy && advance;
    assign o_in_ready  = !r_busy || (advance && seq_last);
    assign accept      = i_in_valid && o_in_ready;
    assign in_cnt      = node_count(i_func);

    // Sequencer control: load a new item or step through its nodes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (accept && (in_cnt != '0)) begin
            r_busy <= 1'b1;
            r_k    <= '0;
        end else if (emit) begin
            if (seq_last) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + NODE_W'(1);
            end
        end
    end

    // Sequencer payload: the item being expanded into nodes.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_func;
            r_x    <= i_xi;
            r_y    <= i_eta;
            r_cnt  <= in_cnt;
        end
    end

    // Linear terms and quadratic factor indices of the current node.
    always_comb begin
        xs    = {{(LIN_W-XW){r_x[XW-1]}}, r_x};
        ys    = {{(LIN_W-XW){r_y[XW-1]}}, r_y};
        lx_m1 = xs - ONE_L;
        lx_p1 = xs + ONE_L;
        l1_mx = ONE_L - xs;
        ly_m1 = ys - ONE_L;
        ly_p1 = ys + ONE_L;
        l1_my = ONE_L - ys;
        ll    = ONE_L - xs - ys;
        x2    = xs <<< 1;
        x4    = xs <<< 2;
        x8    = xs <<< 3;
        y2    = ys <<< 1;
        y4    = ys <<< 2;
        y8    = ys <<< 3;
        one3  = (ONE_L <<< 1) + ONE_L;
        one4  = ONE_L <<< 2;

        // Biquadratic node 3a+b splits into an xi factor a and an eta factor b.
        if (r_k >= NODE_W'(6)) begin
            qa = 2'd2;
            qb = r_k[1:0] - 2'd2;
        end else if (r_k >= NODE_W'(3)) begin
            qa = 2'd1;
            qb = r_k[1:0] - 2'd3;
        end else begin
            qa = 2'd0;
            qb = r_k[1:0];
        end
        ia   = (r_kind == KIND_QUAD2) ? qa : r_k[1:0];
        ea   = (ia != 2'd1);
        eb   = (qb != 2'd1);
        sh_v = SH_3F + SHIFT_W'(ea) + SHIFT_W'(eb);
        sh_d = SH_2F + SHIFT_W'(ea) + SHIFT_W'(eb);
    end

    // Lane operands per element kind and node.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            ops[l] = mk('0, FAC_ONE, UNIT_L, FAC_ONE, SH_0);
        end
        unique case (r_kind)
            KIND_LINE1: begin
                if (r_k == '0) begin
                    ops[LANE_V]  = lin(l1_mx, SH_1);
                    ops[LANE_DX] = lin(-ONE_L, SH_1);
                end else begin
                    ops[LANE_V]  = lin(lx_p1, SH_1);
                    ops[LANE_DX] = lin(ONE_L, SH_1);
                end
            end
            KIND_LINE2: begin
                ops[LANE_V]  = mk(qp(xs, ia), FAC_W'(qq(xs, ia)), UNIT_L, FAC_ONE,
                                  ea ? SH_F1 : SH_F);
                ops[LANE_DX] = lin(qd(xs, ia), ea ? SH_1 : SH_0);
            end
            KIND_QUAD1: begin
                unique case (r_k[1:0])
                    2'd0: begin
                        ops[LANE_V]  = mk(lx_m1, FAC_ONE, ly_m1, FAC_ONE, SH_F2);
                        ops[LANE_DX] = lin(ly_m1, SH_2);
                        ops[LANE_DY] = lin(lx_m1, SH_2);
                    end
                    2'd1: begin
                        ops[LANE_V]  = mk(-lx_p1, FAC_ONE, ly_m1, FAC_ONE, SH_F2);
                        ops[LANE_DX] = lin(l1_my, SH_2);
                        ops[LANE_DY] = lin(-lx_p1, SH_2);
                    end
                    2'd2: begin
                        ops[LANE_V]  = mk(lx_p1, FAC_ONE, ly_p1, FAC_ONE, SH_F2);
                        ops[LANE_DX] = lin(ly_p1, SH_2);
                        ops[LANE_DY] = lin(lx_p1, SH_2);
                    end
                    default: begin
                        ops[LANE_V]  = mk(l1_mx, FAC_ONE, ly_p1, FAC_ONE, SH_F2);
                        ops[LANE_DX] = lin(-ly_p1, SH_2);
                        ops[LANE_DY] = lin(l1_mx, SH_2);
                    end
                endcase
            end
            KIND_QUAD2: begin
                ops[LANE_V]  = mk(qp(xs, ia), FAC_W'(qq(xs, ia)),
                                  qp(ys, qb), FAC_W'(qq(ys, qb)), sh_v);
                ops[LANE_DX] = mk(qd(xs, ia), FAC_ONE,
                                  qp(ys, qb), FAC_W'(qq(ys, qb)), sh_d);
                ops[LANE_DY] = mk(qp(xs, ia), FAC_W'(qq(xs, ia)),
                                  qd(ys, qb), FAC_ONE, sh_d);
            end
            KIND_TRI1: begin
                unique case (r_k[1:0])
                    2'd0: begin
                        ops[LANE_V]  = lin(ll, SH_0);
                        ops[LANE_DX] = lin(-ONE_L, SH_0);
                        ops[LANE_DY] = lin(-ONE_L, SH_0);
                    end
                    2'd1: begin
                        ops[LANE_V]  = lin(xs, SH_0);
                        ops[LANE_DX] = lin(ONE_L, SH_0);
                    end
                    default: begin
                        ops[LANE_V]  = lin(ys, SH_0);
                        ops[LANE_DY] = lin(ONE_L, SH_0);
                    end
                endcase
            end
            KIND_TRI2: begin
                unique case (r_k[2:0])
                    3'd0: begin
                        ops[LANE_V]  = mk(ll, FAC_ONE, ONE_L - x2 - y2, FAC_ONE, SH_F);
                        ops[LANE_DX] = lin(x4 + y4 - one3, SH_0);
                        ops[LANE_DY] = lin(x4 + y4 - one3, SH_0);
                    end
                    3'd1: begin
                        ops[LANE_V]  = mk(xs, FAC_ONE, x2 - ONE_L, FAC_ONE, SH_F);
                        ops[LANE_DX] = lin(x4 - ONE_L, SH_0);
                    end
                    3'd2: begin
                        ops[LANE_V]  = mk(ys, FAC_ONE, y2 - ONE_L, FAC_ONE, SH_F);
                        ops[LANE_DY] = lin(y4 - ONE_L, SH_0);
                    end
                    3'd3: begin
                        ops[LANE_V]  = mk(x4, FAC_ONE, ll, FAC_ONE, SH_F);
                        ops[LANE_DX] = lin(one4 - x8 - y4, SH_0);
                        ops[LANE_DY] = lin(-x4, SH_0);
                    end
                    3'd4: begin
                        ops[LANE_V]  = mk(x4, FAC_ONE, ys, FAC_ONE, SH_F);
                        ops[LANE_DX] = lin(y4, SH_0);
                        ops[LANE_DY] = lin(x4, SH_0);
                    end
                    default: begin
                        ops[LANE_V]  = mk(y4, FAC_ONE, ll, FAC_ONE, SH_F);
                        ops[LANE_DX] = lin(-y4, SH_0);
                        ops[LANE_DY] = lin(one4 - x4 - y8, SH_0);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Factor products; every factor pair is known to fit the operand width.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            mul_a[l] = $signed(r_op1[l].a1) * $signed(r_op1[l].a2);
            mul_b[l] = $signed(r_op1[l].b1) * $signed(r_op1[l].b2);
        end
    end

    // Split operands into a signed high half and an unsigned low half.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            ahe[l] = {r_opa2[l][OP_W-1], r_opa2[l][OP_W-1:HALF_W]};
            ale[l] = {1'b0, r_opa2[l][HALF_W-1:0]};
            bhe[l] = {r_opb2[l][OP_W-1], r_opb2[l][OP_W-1:HALF_W]};
            ble[l] = {1'b0, r_opb2[l][HALF_W-1:0]};
        end
    end

    // Recombine the partial products and add half an output step for rounding.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            rnd[l] = (r_sh3[l] == SH_0) ? '0 : (PROD_W'(1) << (r_sh3[l] - SH_1));
            sum[l] = ({{(PROD_W-PP_W){r_hh3[l][PP_W-1]}}, r_hh3[l]} <<< (2 * HALF_W))
                   + (({{(PROD_W-PP_W){r_hl3[l][PP_W-1]}}, r_hl3[l]}
                      + {{(PROD_W-PP_W){r_lh3[l][PP_W-1]}}, r_lh3[l]}) <<< HALF_W)
                   + {{(PROD_W-PP_W){r_ll3[l][PP_W-1]}}, r_ll3[l]}
                   + rnd[l];
        end
    end

    // Drop the fraction bits and saturate to the result width.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            shifted[l] = r_sum4[l] >>> r_sh4[l];
            if (shifted[l] > SAT_HI) begin
                sat[l] = SAT_HI[OUT_W-1:0];
            end else if (shifted[l] < SAT_LO) begin
                sat[l] = SAT_LO[OUT_W-1:0];
            end else begin
                sat[l] = shifted[l][OUT_W-1:0];
            end
        end
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (advance) begin
            r_vld1 <= emit;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tag1.node <= r_k;
            r_tag1.last <= seq_last;
            r_tag2      <= r_tag1;
            r_tag3      <= r_tag2;
            r_tag4      <= r_tag3;
            r_tag5      <= r_tag4;
            for (int l = 0; l < NLANE; l++) begin
                r_op1[l]  <= ops[l];
                r_opa2[l] <= mul_a[l][OP_W-1:0];
                r_opb2[l] <= mul_b[l][OP_W-1:0];
                r_sh2[l]  <= r_op1[l].sh;
                r_hh3[l]  <= ahe[l] * bhe[l];
                r_hl3[l]  <= ahe[l] * ble[l];
                r_lh3[l]  <= ale[l] * bhe[l];
                r_ll3[l]  <= ale[l] * ble[l];
                r_sh3[l]  <= r_sh2[l];
                r_sum4[l] <= sum[l];
                r_sh4[l]  <= r_sh3[l];
                r_res5[l] <= sat[l];
            end
        end
    end

    // Output ports.
    assign o_out_valid   = r_vld5;
    assign o_node_index  = r_tag5.node;
    assign o_last_node   = r_tag5.last;
    assign o_basis_value = r_res5[LANE_V];
    assign o_deriv_xi    = r_res5[LANE_DX];
    assign o_deriv_eta   = r_res5[LANE_DY];

    // Nodes of one element leave back to back, in ascending order.
    a_node_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_node)
        |=> (o_out_valid && (o_node_index == $past(o_node_index) + NODE_W'(1))))
        else $error("node order broken within an element");

    // After the last node of an element, the next result starts a fresh element.
    a_node_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_node)
        |=> (!o_out_valid || (o_node_index == '0)))
        else $error("element did not restart at node zero");

    // The sequencer never runs past the node count of its element.
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k < r_cnt))
        else $error("sequencer node counter out of range");

    // An accepted item with nodes starts the sequencer at node zero.
    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (node_count(i_func) != '0))
        |=> (r_busy && (r_k == '0)))
        else $error("sequencer did not start on an accepted item");

endmodule

// ===== tb/lagrange_shape_function_eval_tb.sv =====
// Self-checking testbench for the Lagrange shape function evaluator.
`timescale 1ns / 1ps

module lagrange_shape_function_eval_tb;

    import lsfe_pkg::*;

    // Fixed-point constants of the coordinate and result format.
    localparam int ONE  = 1 << FRAC_BITS;
    localparam int HALF = ONE / 2;
    localparam int SAT_POS = (1 << (OUT_W - 1)) - 1;

    // Kind codes that the block must ignore.
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    // Run control.
    localparam int N_DIR        = 25;
    localparam int N_RANDOM     = 285;
    localparam int CALM_TAIL    = 40;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_PRINTS   = 30;

    typedef logic signed [127:0] t_wide;

    // One request: element kind and point, plus an optional typed-in first node.
    typedef struct packed {
        logic [2:0]                kind;
        logic signed [XW-1:0]      xi;
        logic signed [XW-1:0]      eta;
        logic                      typed;
        logic signed [OUT_W-1:0]   tv;
        logic signed [OUT_W-1:0]   tdx;
        logic signed [OUT_W-1:0]   tdy;
    } t_shape_req;

    // One node result as the block should deliver it.
    typedef struct packed {
        logic [NODE_W-1:0]         node;
        logic signed [OUT_W-1:0]   value;
        logic signed [OUT_W-1:0]   dxi;
        logic signed [OUT_W-1:0]   deta;
        logic                      last;
    } t_node_res;

    // Directed table: node points, extremes, rounding ties, saturation and unused codes.
    // Typed rows carry the first node's value and derivatives as read off the formulas.
    localparam t_shape_req DIR_TAB [N_DIR] = '{
        '{KIND_LINE1, -ONE, 0, 1'b1, ONE, -HALF, 0},
        '{KIND_LINE1, ONE, 0, 1'b1, 0, -HALF, 0},
        '{KIND_LINE1, 1, 0, 1'b0, 0, 0, 0},
        '{KIND_LINE1, -1, 131071, 1'b0, 0, 0, 0},
        '{KIND_LINE2, -ONE, 0, 1'b1, ONE, -3 * HALF, 0},
        '{KIND_LINE2, 0, 0, 1'b1, 0, -HALF, 0},
        '{KIND_LINE2, -131072, 0, 1'b0, 0, 0, 0},
        '{KIND_QUAD1, -ONE, -ONE, 1'b1, ONE, -HALF, -HALF},
        '{KIND_QUAD1, ONE, ONE, 1'b0, 0, 0, 0},
        '{KIND_QUAD1, HALF, -16384, 1'b0, 0, 0, 0},
        '{KIND_QUAD2, -ONE, -ONE, 1'b1, ONE, -3 * HALF, -3 * HALF},
        '{KIND_QUAD2, 0, 0, 1'b0, 0, 0, 0},
        '{KIND_QUAD2, -131072, -131072, 1'b1, SAT_POS, -491520, -491520},
        '{KIND_QUAD2, 131071, -131072, 1'b0, 0, 0, 0},
        '{KIND_TRI1, 0, 0, 1'b1, ONE, -ONE, -ONE},
        '{KIND_TRI1, ONE, 0, 1'b0, 0, 0, 0},
        '{KIND_TRI1, 0, ONE, 1'b0, 0, 0, 0},
        '{KIND_TRI2, 0, 0, 1'b1, ONE, -3 * ONE, -3 * ONE},
        '{KIND_TRI2, HALF, HALF, 1'b0, 0, 0, 0},
        '{KIND_TRI2, 0, HALF, 1'b0, 0, 0, 0},
        '{KIND_TRI2, 0, ONE, 1'b0, 0, 0, 0},
        '{KIND_TRI2, 131071, 131071, 1'b1, SAT_POS, SAT_POS, SAT_POS},
        '{KIND_TRI2, 131071, 0, 1'b0, 0, 0, 0},
        '{KIND_SPARE6, 0, 0, 1'b1, 0, 0, 0},
        '{KIND_SPARE7, -1, -1, 1'b1, 0, 0, 0}
    };

    // Block connections; every input starts at a known value.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [2:0]                func      = '0;
    logic signed [XW-1:0]      xi        = '0;
    logic signed [XW-1:0]      eta       = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [NODE_W-1:0]         node_index;
    logic signed [OUT_W-1:0]   basis_value;
    logic signed [OUT_W-1:0]   deriv_xi;
    logic signed [OUT_W-1:0]   deriv_eta;
    logic                      last_node;

    // Stimulus, expected node results and run bookkeeping.
    t_shape_req  stim_q[$];
    t_node_res   node_expect_q[$];
    int          send_idx     = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          cycle_cnt    = 0;
    int          mismatch_cnt = 0;
    int          result_cnt   = 0;
    int          typed_cnt    = 0;
    int          kind_cnt [8];
    logic        all_drained  = 1'b0;

    lagrange_shape_function_eval DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_func        (func),
        .i_xi          (xi),
        .i_eta         (eta),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_node_index  (node_index),
        .o_basis_value (basis_value),
        .o_deriv_xi    (deriv_xi),
        .o_deriv_eta   (deriv_eta),
        .o_last_node   (last_node)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Exact product a*b at scale 2^-t, rounded to nearest (ties upward) and saturated.
    function automatic logic signed [OUT_W-1:0] round_sat(input t_wide a, input t_wide b,
                                                           input int t);
        t_wide p;
        int    s;
        p = a * b;
        s = t - FRAC_BITS;
        if (s > 0) begin
            p = (p + (t_wide'(1) <<< (s - 1))) >>> s;
        end
        if (p > t_wide'(SAT_POS)) begin
            return OUT_W'(SAT_POS);
        end
        if (p < -t_wide'(SAT_POS) - 1) begin
            return OUT_W'(-SAT_POS - 1);
        end
        return p[OUT_W-1:0];
    endfunction

    task automatic add_node(input int k, input int n, input logic signed [OUT_W-1:0] v,
                            input logic signed [OUT_W-1:0] dx,
                            input logic signed [OUT_W-1:0] dy);
        t_node_res r;
        r.node  = NODE_W'(k);
        r.value = v;
        r.dxi   = dx;
        r.deta  = dy;
        r.last  = (k == n - 1);
        node_expect_q.push_back(r);
    endtask

    // Works out every node result of one element at one point, in node order.
    task automatic eval_shape_nodes(input logic [2:0] kind, input logic signed [XW-1:0] xr,
                                    input logic signed [XW-1:0] er);
        t_wide x, y, one, l;
        t_wide fx [3];
        t_wide dfx [3];
        t_wide fy [3];
        t_wide dfy [3];
        int    fs [3];
        int    ds [3];
        x   = xr;
        y   = er;
        one = t_wide'(1) <<< FRAC_BITS;
        l   = one - x - y;
        // One-dimensional quadratic factors for the nodes at -1, 0 and +1.
        fs  = '{2 * FRAC_BITS + 1, 2 * FRAC_BITS, 2 * FRAC_BITS + 1};
        ds  = '{FRAC_BITS + 1, FRAC_BITS, FRAC_BITS + 1};
        fx[0] = x * (x - one);  fx[1] = one * one - x * x;  fx[2] = x * (x + one);
        dfx[0] = 2 * x - one;   dfx[1] = -2 * x;            dfx[2] = 2 * x + one;
        fy[0] = y * (y - one);  fy[1] = one * one - y * y;  fy[2] = y * (y + one);
        dfy[0] = 2 * y - one;   dfy[1] = -2 * y;            dfy[2] = 2 * y + one;
        case (kind)
            KIND_LINE1: begin
                add_node(0, 2, round_sat(one - x, 1, FRAC_BITS + 1),
                         round_sat(-one, 1, FRAC_BITS + 1), 0);
                add_node(1, 2, round_sat(x + one, 1, FRAC_BITS + 1),
                         round_sat(one, 1, FRAC_BITS + 1), 0);
            end
            KIND_LINE2: begin
                for (int a = 0; a < 3; a++) begin
                    add_node(a, 3, round_sat(fx[a], 1, fs[a]), round_sat(dfx[a], 1, ds[a]), 0);
                end
            end
            KIND_QUAD1: begin
                add_node(0, 4, round_sat(x - one, y - one, 2 * FRAC_BITS + 2),
                         round_sat(y - one, 1, FRAC_BITS + 2),
                         round_sat(x - one, 1, FRAC_BITS + 2));
                add_node(1, 4, round_sat(-(x + one), y - one, 2 * FRAC_BITS + 2),
                         round_sat(one - y, 1, FRAC_BITS + 2),
                         round_sat(-(x + one), 1, FRAC_BITS + 2));
                add_node(2, 4, round_sat(x + one, y + one, 2 * FRAC_BITS + 2),
                         round_sat(y + one, 1, FRAC_BITS + 2),
                         round_sat(x + one, 1, FRAC_BITS + 2));
                add_node(3, 4, round_sat(one - x, y + one, 2 * FRAC_BITS + 2),
                         round_sat(-(y + one), 1, FRAC_BITS + 2),
                         round_sat(one - x, 1, FRAC_BITS + 2));
            end
            KIND_QUAD2: begin
                // Node 3a+b takes xi factor a and eta factor b.
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 3; b++) begin
                        add_node(3 * a + b, 9, round_sat(fx[a], fy[b], fs[a] + fs[b]),
                                 round_sat(dfx[a], fy[b], ds[a] + fs[b]),
                                 round_sat(fx[a], dfy[b], fs[a] + ds[b]));
                    end
                end
            end
            KIND_TRI1: begin
                add_node(0, 3, round_sat(l, 1, FRAC_BITS), round_sat(-one, 1, FRAC_BITS),
                         round_sat(-one, 1, FRAC_BITS));
                add_node(1, 3, round_sat(x, 1, FRAC_BITS), round_sat(one, 1, FRAC_BITS), 0);
                add_node(2, 3, round_sat(y, 1, FRAC_BITS), 0, round_sat(one, 1, FRAC_BITS));
            end
            KIND_TRI2: begin
                add_node(0, 6, round_sat(l, one - 2 * x - 2 * y, 2 * FRAC_BITS),
                         round_sat(4 * x + 4 * y - 3 * one, 1, FRAC_BITS),
                         round_sat(4 * x + 4 * y - 3 * one, 1, FRAC_BITS));
                add_node(1, 6, round_sat(x, 2 * x - one, 2 * FRAC_BITS),
                         round_sat(4 * x - one, 1, FRAC_BITS), 0);
                // Third vertex: eta(2 eta - 1).
                add_node(2, 6, round_sat(y, 2 * y - one, 2 * FRAC_BITS), 0,
                         round_sat(4 * y - one, 1, FRAC_BITS));
                add_node(3, 6, round_sat(4 * x, l, 2 * FRAC_BITS),
                         round_sat(4 * one - 8 * x - 4 * y, 1, FRAC_BITS),
                         round_sat(-4 * x, 1, FRAC_BITS));
                add_node(4, 6, round_sat(4 * x, y, 2 * FRAC_BITS),
                         round_sat(4 * y, 1, FRAC_BITS), round_sat(4 * x, 1, FRAC_BITS));
                // Last edge midpoint: 4 eta (1 - xi - eta).
                add_node(5, 6, round_sat(4 * y, l, 2 * FRAC_BITS),
                         round_sat(-4 * y, 1, FRAC_BITS),
                         round_sat(4 * one - 4 * x - 8 * y, 1, FRAC_BITS));
            end
            default: begin
                // Unused codes produce no nodes.
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_cnt < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got,
                     want);
        end
        mismatch_cnt++;
    endtask

    // Compares one transferred result with the oldest expectation.
    task automatic check_result();
        t_node_res want;
        if (node_expect_q.size() == 0) begin
            report_mismatch("result with nothing pending, node", node_index, -1);
            return;
        end
        want = node_expect_q.pop_front();
        result_cnt++;
        if (node_index !== want.node) report_mismatch("node_index", node_index, want.node);
        if (basis_value !== want.value) report_mismatch("basis_value", basis_value, want.value);
        if (deriv_xi !== want.dxi) report_mismatch("deriv_xi", deriv_xi, want.dxi);
        if (deriv_eta !== want.deta) report_mismatch("deriv_eta", deriv_eta, want.deta);
        if (last_node !== want.last) report_mismatch("last_node", last_node, want.last);
    endtask

    // Coordinates: mostly inside the reference element, some node points, some full range.
    function automatic logic signed [XW-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return XW'($urandom);
        end else if (sel == 1) begin
            return XW'((int'($urandom_range(0, 4)) - 2) * HALF);
        end
        return XW'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    // Idle density varies by stretch of the run and drops to nothing near the end.
    function automatic int idle_pct(input int idx, input int total);
        if (idx >= total - CALM_TAIL) begin
            return 0;
        end
        case ((idx / 40) % 3)
            0:       return 15;
            1:       return 0;
            default: return 40;
        endcase
    endfunction

    // Drives both channels, predicts on each input transfer and checks each result.
    always @(posedge clk) begin : drive_and_check
        t_shape_req req;
        int         base;
        int         pct;
        t_node_res  fixed;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            pct = idle_pct(send_idx, stim_q.size());

            // Result side.
            if (out_valid && out_ready) begin
                check_result();
            end

            // Input side: record the transfer and queue its node results.
            if (in_valid && in_ready) begin
                req  = stim_q[send_idx];
                base = node_expect_q.size();
                eval_shape_nodes(req.kind, req.xi, req.eta);
                if (req.typed && node_expect_q.size() > base) begin
                    fixed       = node_expect_q[base];
                    fixed.value = req.tv;
                    fixed.dxi   = req.tdx;
                    fixed.deta  = req.tdy;
                    node_expect_q[base] = fixed;
                    typed_cnt++;
                end
                kind_cnt[req.kind]++;
                send_idx++;
                if ($urandom_range(0, 99) < pct) begin
                    gap_left = $urandom_range(1, 11);
                end
            end

            // Present the next item unless idling or waiting for the pipeline to empty.
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if ((send_idx == N_DIR || send_idx == N_DIR + 150)
                             && node_expect_q.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (send_idx < stim_q.size()) begin
                    req = stim_q[send_idx];
                    in_valid <= 1'b1;
                    func     <= req.kind;
                    xi       <= req.xi;
                    eta      <= req.eta;
                end else begin
                    in_valid <= 1'b0;
                end
            end

            // Result back-pressure in bursts.
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < pct) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end

            all_drained <= (send_idx == stim_q.size()) && (node_expect_q.size() == 0);
        end
    end

    // Stimulus build, reset, end of run.
    initial begin
        t_shape_req req;
        int         useful;
        foreach (kind_cnt[k]) kind_cnt[k] = 0;
        for (int i = 0; i < N_DIR; i++) begin
            stim_q.push_back(DIR_TAB[i]);
        end
        useful = 0;
        while (useful < N_RANDOM) begin
            req = '0;
            if ($urandom_range(0, 24) == 0) begin
                req.kind = $urandom_range(0, 1) ? KIND_SPARE7 : KIND_SPARE6;
            end else begin
                req.kind = 3'($urandom_range(0, 5));
                useful++;
            end
            req.xi  = rand_coord();
            req.eta = rand_coord();
            stim_q.push_back(req);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (all_drained);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d elements (line %0d/%0d, quad %0d/%0d, tri %0d/%0d, unused %0d).",
                 send_idx, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4],
                 kind_cnt[5], kind_cnt[6] + kind_cnt[7]);
        $display("Checked %0d node results (%0d against fixed values), %0d mismatches.",
                 result_cnt, typed_cnt, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog on the cycle count.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped by the watchdog after %0d cycles.", cycle_cnt);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lsfe_pkg.sv
rtl/lagrange_shape_function_eval.sv
tb/lagrange_shape_function_eval_tb.sv
